[hw/rtl/rtu_frame_receiver_assert.svh]
// Assertion macros for the RTU receive framer.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef RTU_FRAME_RECEIVER_ASSERT_SVH
`define RTU_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RTU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtu framer check failed");

// Next-cycle implication, disabled while in reset.
`define RTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtu framer check failed");

`endif

[hw/rtl/rtu_pkg.sv]
// Shared types, codes and the CRC-16 step for the RTU receive framer.
// No dependencies.
package rtu_pkg;

  localparam int unsigned MIN_FRAME   = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_BYTE   = 2'd1,
    ACT_EXPIRE = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_STARTUP = 2'd1,
    EV_FRAME   = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    CMD_NOP    = 3'd0,
    CMD_START  = 3'd1,
    CMD_BYTE   = 3'd2,
    CMD_EXPIRE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] port;
    logic [7:0] data_byte;
    logic [7:0] pdu_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       timer_restart;
    logic       frame_ok;
    logic [7:0] address;
    logic [7:0] pdu_length;
    logic [7:0] read_data;
  } out_item_t;

  // Classified event as it travels from front to back
  typedef struct packed {
    cmd_e       op;
    logic [1:0] port;
    logic [7:0] data_byte;
    logic [7:0] rd_off;
  } cmd_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/rtu_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module rtu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/rtu_front.sv]
// Front end: classifies an incoming event into a command for the back end.
// Depends on rtu_pkg.
module rtu_front #(
  parameter int unsigned PORT_COUNT = 4,
  parameter int unsigned FRAME_MAX  = 256
) (
  input  rtu_pkg::in_item_t in_item_i,
  output rtu_pkg::cmd_t     cmd_o
);

  logic       port_ok;
  logic [8:0] rd_next;
  logic       rd_ok;

  assign port_ok = (32'(in_item_i.port) < PORT_COUNT);
  assign rd_next = {1'b0, in_item_i.pdu_index} + 9'd1;
  assign rd_ok   = (32'(rd_next) < FRAME_MAX);

  always_comb begin
    cmd_o.port      = in_item_i.port;
    cmd_o.data_byte = in_item_i.data_byte;
    cmd_o.rd_off    = rd_next[7:0];
    cmd_o.op        = rtu_pkg::CMD_NOP;
    if (port_ok) begin
      unique case (rtu_pkg::action_e'(in_item_i.action))
        rtu_pkg::ACT_START:  cmd_o.op = rtu_pkg::CMD_START;
        rtu_pkg::ACT_BYTE:   cmd_o.op = rtu_pkg::CMD_BYTE;
        rtu_pkg::ACT_EXPIRE: cmd_o.op = rtu_pkg::CMD_EXPIRE;
        // a read past the frame buffer answers zero
        rtu_pkg::ACT_READ:   cmd_o.op = rd_ok ? rtu_pkg::CMD_READ : rtu_pkg::CMD_NOP;
        default:             cmd_o.op = rtu_pkg::CMD_NOP;
      endcase
    end
  end

endmodule

[hw/rtl/rtu_queue.sv]
// Short command queue between front and back end.
// Depends on rtu_pkg.
module rtu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  rtu_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output rtu_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned IW = (rtu_pkg::QUEUE_DEPTH > 1) ? $clog2(rtu_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(rtu_pkg::QUEUE_DEPTH + 1);

  rtu_pkg::cmd_t   slot_q [rtu_pkg::QUEUE_DEPTH];
  logic [IW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [IW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != NW'(rtu_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == IW'(rtu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + IW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == IW'(rtu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + IW'(1);
    end
    count_d = count_q + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[hw/rtl/rtu_back.sv]
// Back end: per-port receive state, frame buffer access and result register.
// Depends on rtu_pkg and rtu_ram.
module rtu_back #(
  parameter int unsigned PORT_COUNT = 4,
  parameter int unsigned FRAME_MAX  = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  rtu_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rtu_pkg::out_item_t out_item_o
);

  localparam int unsigned PW    = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int unsigned CW    = $clog2(FRAME_MAX + 1);
  localparam int unsigned DEPTH = PORT_COUNT * FRAME_MAX;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_IDLE = 2'd1,
    MODE_RCV  = 2'd2,
    MODE_ERR  = 2'd3
  } mode_e;

  mode_e         mode_q [PORT_COUNT];
  logic [CW-1:0] cnt_q  [PORT_COUNT];
  logic [15:0]   crc_q  [PORT_COUNT];

  logic          fire;
  logic [PW-1:0] pi;
  mode_e         mode_cur, mode_d;
  logic [CW-1:0] cnt_cur, cnt_d;
  logic [15:0]   crc_cur, crc_d;
  logic [AW-1:0] base;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  logic [1:0]    ev_q, ev_d;
  logic          tr_q, tr_d;
  logic          ok_q, ok_d;
  logic [7:0]    plen_q, plen_d;
  logic          sel_addr_q, sel_addr_d;
  logic          sel_rd_q, sel_rd_d;
  logic          out_valid_q;

  // advance while the result register is empty or being drained
  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;

  assign pi       = PW'(cmd_i.port);
  assign mode_cur = mode_q[pi];
  assign cnt_cur  = cnt_q[pi];
  assign crc_cur  = crc_q[pi];
  assign base     = AW'(int'(pi) * FRAME_MAX);

  always_comb begin
    mode_d     = mode_cur;
    cnt_d      = cnt_cur;
    crc_d      = crc_cur;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = base;
    ev_d       = rtu_pkg::EV_NONE;
    tr_d       = 1'b0;
    ok_d       = 1'b0;
    plen_d     = '0;
    sel_addr_d = 1'b0;
    sel_rd_d   = 1'b0;
    unique case (cmd_i.op)
      rtu_pkg::CMD_START: begin
        mode_d = MODE_INIT;
        tr_d   = 1'b1;
      end
      rtu_pkg::CMD_BYTE: begin
        tr_d = 1'b1;
        if (mode_cur == MODE_IDLE) begin
          ram_we = fire;
          cnt_d  = CW'(1);
          crc_d  = rtu_pkg::crc_feed(rtu_pkg::CRC_INIT, cmd_i.data_byte);
          mode_d = MODE_RCV;
        end else if (mode_cur == MODE_RCV) begin
          if (cnt_cur < CW'(FRAME_MAX)) begin
            ram_we   = fire;
            ram_addr = base + AW'(cnt_cur);
            cnt_d    = cnt_cur + CW'(1);
            crc_d    = rtu_pkg::crc_feed(crc_cur, cmd_i.data_byte);
          end else begin
            // drop the byte, the frame is too long
            mode_d = MODE_ERR;
          end
        end
      end
      rtu_pkg::CMD_EXPIRE: begin
        if (mode_cur == MODE_INIT) begin
          ev_d = rtu_pkg::EV_STARTUP;
        end else if (mode_cur == MODE_RCV) begin
          ev_d       = rtu_pkg::EV_FRAME;
          ok_d       = (cnt_cur >= CW'(rtu_pkg::MIN_FRAME)) && (crc_cur == '0);
          plen_d     = (cnt_cur >= CW'(3)) ? 8'(cnt_cur - CW'(3)) : '0;
          ram_re     = fire;
          sel_addr_d = 1'b1;
        end
        mode_d = MODE_IDLE;
      end
      rtu_pkg::CMD_READ: begin
        ram_re   = fire;
        ram_addr = base + AW'(cmd_i.rd_off);
        sel_rd_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  rtu_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (cmd_i.data_byte),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PORT_COUNT; p++) begin
        mode_q[p] <= MODE_INIT;
        cnt_q[p]  <= '0;
        crc_q[p]  <= rtu_pkg::CRC_INIT;
      end
      out_valid_q <= 1'b0;
      ev_q        <= rtu_pkg::EV_NONE;
      tr_q        <= 1'b0;
      ok_q        <= 1'b0;
      plen_q      <= '0;
      sel_addr_q  <= 1'b0;
      sel_rd_q    <= 1'b0;
    end else begin
      if (fire) begin
        if (cmd_i.op != rtu_pkg::CMD_NOP) begin
          mode_q[pi] <= mode_d;
          cnt_q[pi]  <= cnt_d;
          crc_q[pi]  <= crc_d;
        end
        out_valid_q <= 1'b1;
        ev_q        <= ev_d;
        tr_q        <= tr_d;
        ok_q        <= ok_d;
        plen_q      <= plen_d;
        sel_addr_q  <= sel_addr_d;
        sel_rd_q    <= sel_rd_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // buffer data holds while stalled: the RAM reads only on fire
  assign out_valid_o              = out_valid_q;
  assign out_item_o.event_res     = ev_q;
  assign out_item_o.timer_restart = tr_q;
  assign out_item_o.frame_ok      = ok_q;
  assign out_item_o.address       = sel_addr_q ? ram_rdata : '0;
  assign out_item_o.pdu_length    = plen_q;
  assign out_item_o.read_data     = sel_rd_q ? ram_rdata : '0;

endmodule

[hw/rtl/rtu_frame_receiver.sv]
// Top level of the RTU receive framer: front classifier, command queue, back end.
// Depends on rtu_pkg, rtu_front, rtu_queue, rtu_back and the assertion header.
//
//   channel | signals                            | beat
//   --------+------------------------------------+-----------------------------
//   in      | in_valid_i, in_ready_o, in_item_i   | one port event
//   out     | out_valid_o, out_ready_i, out_item_o| one result per event
//
// One event per cycle sustained while the output is not stalled; an event taken is
// written to a queue slot, then the back end does the per-port state update and frame
// buffer read and registers the result.
// Reset returns every port to init with count zero and CRC 0xFFFF at once; the
// frame buffer is not cleared and needs no sweep.
// A stalled output holds the back end; the two-entry queue keeps taking events
// until it fills.
`include "rtu_frame_receiver_assert.svh"

module rtu_frame_receiver #(
  parameter int unsigned PORT_COUNT = 4,
  parameter int unsigned FRAME_MAX  = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rtu_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rtu_pkg::out_item_t out_item_o
);

  rtu_pkg::cmd_t front_cmd;
  rtu_pkg::cmd_t queue_cmd;
  logic          cmd_valid;
  logic          cmd_ready;

  rtu_front #(
    .PORT_COUNT (PORT_COUNT),
    .FRAME_MAX  (FRAME_MAX)
  ) u_front (
    .in_item_i (in_item_i),
    .cmd_o     (front_cmd)
  );

  rtu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (cmd_valid),
    .pop_ready_i  (cmd_ready),
    .pop_cmd_o    (queue_cmd)
  );

  rtu_back #(
    .PORT_COUNT (PORT_COUNT),
    .FRAME_MAX  (FRAME_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (queue_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // an accepted event is queued for the back end on the next cycle
  `RTU_ASSERT_NEXT(a_in_reaches_queue, clk_i, rst_ni, in_valid_i && in_ready_o, cmd_valid)
  // a command taken by the back end yields a result on the next cycle
  `RTU_ASSERT_NEXT(a_cmd_gives_result, clk_i, rst_ni, cmd_valid && cmd_ready, out_valid_o)
  // the back end must not advance over a stalled result
  `RTU_ASSERT_NOW(a_hold_on_stall, clk_i, rst_ni, out_valid_o && !out_ready_i, !cmd_ready)

endmodule

[tb/tb_top.sv]
// Self-checking testbench for rtu_frame_receiver: directed and random port events.
// Depends on rtu_pkg and the rtu_frame_receiver RTL; keeps its own per-port model.
module tb_top;

  typedef enum logic [1:0] {
    RX_INIT    = 2'd0,
    RX_IDLE    = 2'd1,
    RX_RECEIVE = 2'd2,
    RX_ERROR   = 2'd3
  } rx_mode_e;

  localparam int unsigned PORTS     = 4;
  localparam int unsigned FRAME_CAP = 256;
  localparam int unsigned PRINT_CAP = 30;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  rtu_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  rtu_pkg::out_item_t out_item_o;

  // Model of the framer
  rx_mode_e    port_mode [PORTS];
  logic [8:0]  port_count [PORTS];
  logic [15:0] port_crc [PORTS];
  logic [7:0]  rx_store [0:PORTS*FRAME_CAP-1];
  int unsigned store_fill [PORTS];

  rtu_pkg::out_item_t pending_responses [$];
  int unsigned events_sent;
  int unsigned responses_checked;
  int unsigned frames_reported;
  int unsigned frames_good;
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  rtu_frame_receiver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
    int k;
    acc = acc ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ rtu_pkg::CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic rtu_pkg::out_item_t framer_response(rtu_pkg::in_item_t it);
    rtu_pkg::out_item_t r;
    int unsigned p;
    int unsigned base;
    int unsigned n;
    r = '0;
    p = it.port;
    base = p * FRAME_CAP;
    case (rtu_pkg::action_e'(it.action))
      rtu_pkg::ACT_START: begin
        port_mode[p] = RX_INIT;
        r.timer_restart = 1'b1;
      end
      rtu_pkg::ACT_BYTE: begin
        r.timer_restart = 1'b1;
        if (port_mode[p] == RX_IDLE) begin
          rx_store[base] = it.data_byte;
          port_count[p] = 9'd1;
          port_crc[p] = crc16_step(rtu_pkg::CRC_INIT, it.data_byte);
          port_mode[p] = RX_RECEIVE;
        end else if (port_mode[p] == RX_RECEIVE) begin
          if (port_count[p] < FRAME_CAP) begin
            rx_store[base + port_count[p]] = it.data_byte;
            port_count[p] = port_count[p] + 9'd1;
            port_crc[p] = crc16_step(port_crc[p], it.data_byte);
          end else begin
            port_mode[p] = RX_ERROR;
          end
        end
        if (port_count[p] > store_fill[p]) store_fill[p] = port_count[p];
      end
      rtu_pkg::ACT_EXPIRE: begin
        if (port_mode[p] == RX_INIT) begin
          r.event_res = rtu_pkg::EV_STARTUP;
        end else if (port_mode[p] == RX_RECEIVE) begin
          n = port_count[p];
          r.event_res = rtu_pkg::EV_FRAME;
          r.frame_ok = (n >= rtu_pkg::MIN_FRAME) && (port_crc[p] == 16'h0000);
          r.address = rx_store[base];
          r.pdu_length = (n >= 3) ? 8'(n - 3) : 8'd0;
        end
        port_mode[p] = RX_IDLE;
      end
      default: begin
        if (it.pdu_index + 1 < FRAME_CAP) r.read_data = rx_store[base + it.pdu_index + 1];
      end
    endcase
    return r;
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("tb_top: mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin : check_responses
    rtu_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_responses.size() == 0) begin
        report_error("result beat with nothing outstanding");
      end else begin
        want = pending_responses.pop_front();
        responses_checked++;
        if (want.event_res == rtu_pkg::EV_FRAME) begin
          frames_reported++;
          if (want.frame_ok) frames_good++;
        end
        compare_field("event_res", out_item_o.event_res, want.event_res);
        compare_field("timer_restart", out_item_o.timer_restart, want.timer_restart);
        compare_field("frame_ok", out_item_o.frame_ok, want.frame_ok);
        compare_field("address", out_item_o.address, want.address);
        compare_field("pdu_length", out_item_o.pdu_length, want.pdu_length);
        compare_field("read_data", out_item_o.read_data, want.read_data);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_event(rtu_pkg::action_e act, logic [1:0] p, logic [7:0] data,
                            logic [7:0] idx);
    rtu_pkg::in_item_t it;
    it.action = act;
    it.port = p;
    it.data_byte = (act == rtu_pkg::ACT_BYTE) ? data : 8'($urandom);
    it.pdu_index = (act == rtu_pkg::ACT_READ) ? idx : 8'($urandom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pending_responses.push_back(framer_response(it));
    events_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(logic [1:0] p, logic [7:0] b);
    send_event(rtu_pkg::ACT_BYTE, p, b, 8'h00);
  endtask

  task automatic send_plain(rtu_pkg::action_e act, logic [1:0] p);
    send_event(act, p, 8'h00, 8'h00);
  endtask

  // Only offsets that hold a stored byte are read, plus the out-of-range index.
  task automatic send_read(logic [1:0] p);
    logic [7:0] idx;
    if (store_fill[p] >= 2 && $urandom_range(9) != 0) begin
      idx = 8'($urandom_range(store_fill[p] - 2, 0));
    end else if (store_fill[p] == FRAME_CAP) begin
      idx = 8'($urandom_range(255, 253));
    end else begin
      idx = 8'd255;
    end
    send_event(rtu_pkg::ACT_READ, p, 8'h00, idx);
  endtask

  // Bytes of one frame; a good frame of three bytes or more ends in its CRC, low byte first.
  task automatic send_frame(logic [1:0] p, int unsigned len, bit good, bit mix);
    logic [15:0] acc;
    logic [15:0] sealed;
    logic [7:0]  b;
    int unsigned i;
    acc = rtu_pkg::CRC_INIT;
    sealed = rtu_pkg::CRC_INIT;
    for (i = 0; i < len; i++) begin
      if (good && len >= 3 && i == len - 2) sealed = acc;
      if (good && len >= 3 && i == len - 2) b = sealed[7:0];
      else if (good && len >= 3 && i == len - 1) b = sealed[15:8];
      else b = 8'($urandom);
      acc = crc16_step(acc, b);
      if (mix && $urandom_range(9) == 0) send_read(2'($urandom));
      send_byte(p, b);
    end
  endtask

  task automatic make_idle(logic [1:0] p);
    if (port_mode[p] != RX_IDLE) send_plain(rtu_pkg::ACT_EXPIRE, p);
  endtask

  task automatic wait_for_responses();
    int unsigned cycles;
    cycles = 0;
    in_valid_i <= 1'b0;
    while (pending_responses.size() != 0 && cycles < 5000) begin
      @(negedge clk_i);
      cycles++;
    end
    if (pending_responses.size() != 0) begin
      report_error($sformatf("%0d results never arrived", pending_responses.size()));
      pending_responses.delete();
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic test_startup();
    int p;
    for (p = 0; p < PORTS; p++) begin
      send_plain(rtu_pkg::ACT_START, 2'(p));
      send_plain(rtu_pkg::ACT_EXPIRE, 2'(p));
    end
    send_plain(rtu_pkg::ACT_EXPIRE, 2'd0);
    send_event(rtu_pkg::ACT_READ, 2'd0, 8'h00, 8'd255);
    send_plain(rtu_pkg::ACT_START, 2'd1);
    send_byte(2'd1, 8'hFF);
    send_plain(rtu_pkg::ACT_EXPIRE, 2'd1);
    wait_for_responses();
  endtask

  task automatic test_good_frame();
    send_frame(2'd0, 8, 1'b1, 1'b0);
    send_plain(rtu_pkg::ACT_EXPIRE, 2'd0);
    send_event(rtu_pkg::ACT_READ, 2'd0, 8'h00, 8'd0);
    send_event(rtu_pkg::ACT_READ, 2'd0, 8'h00, 8'd4);
    send_byte(2'd1, 8'h00);
    send_frame(2'd1, 9, 1'b0, 1'b0);
    send_plain(rtu_pkg::ACT_EXPIRE, 2'd1);
    wait_for_responses();
  endtask

  // Short frames still report address and length.
  task automatic test_short_frames();
    int unsigned len;
    for (len = 1; len <= 3; len++) begin
      send_frame(2'd2, len, 1'b1, 1'b0);
      send_plain(rtu_pkg::ACT_EXPIRE, 2'd2);
    end
    send_frame(2'd2, 7, 1'b1, 1'b0);
    send_plain(rtu_pkg::ACT_EXPIRE, 2'd2);
    wait_for_responses();
  endtask

  task automatic test_frame_limits();
    send_frame(2'd3, FRAME_CAP, 1'b1, 1'b0);
    send_plain(rtu_pkg::ACT_EXPIRE, 2'd3);
    send_event(rtu_pkg::ACT_READ, 2'd3, 8'h00, 8'd252);
    send_event(rtu_pkg::ACT_READ, 2'd3, 8'h00, 8'd253);
    send_event(rtu_pkg::ACT_READ, 2'd3, 8'h00, 8'd254);
    // drop both bytes past the cap; the first puts the port in error
    send_frame(2'd0, FRAME_CAP + 2, 1'b0, 1'b0);
    send_plain(rtu_pkg::ACT_EXPIRE, 2'd0);
    send_plain(rtu_pkg::ACT_EXPIRE, 2'd0);
    send_event(rtu_pkg::ACT_READ, 2'd0, 8'h00, 8'd254);
    send_frame(2'd1, 5, 1'b0, 1'b0);
    send_plain(rtu_pkg::ACT_START, 2'd1);
    send_plain(rtu_pkg::ACT_EXPIRE, 2'd1);
    wait_for_responses();
  endtask

  task automatic test_random(int unsigned idle_pct, int unsigned stall_pct, int unsigned n);
    int unsigned first;
    int unsigned k;
    int unsigned len;
    int unsigned i;
    logic [1:0]  p;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first = events_sent;
    while (events_sent - first < n) begin
      k = $urandom_range(99);
      p = 2'($urandom);
      if (k < 60) begin
        make_idle(p);
        len = $urandom_range(20, 1);
        send_frame(p, len, $urandom_range(3) != 0, 1'b1);
        send_plain(rtu_pkg::ACT_EXPIRE, p);
        repeat ($urandom_range(3)) send_read(p);
      end else if (k < 72) begin
        send_plain(rtu_pkg::ACT_START, p);
        repeat ($urandom_range(2)) send_byte(p, 8'($urandom));
        send_plain(rtu_pkg::ACT_EXPIRE, p);
      end else if (k < 85) begin
        case (rtu_pkg::action_e'($urandom_range(3)))
          rtu_pkg::ACT_START:  send_plain(rtu_pkg::ACT_START, p);
          rtu_pkg::ACT_BYTE:   send_byte(p, 8'($urandom));
          rtu_pkg::ACT_EXPIRE: send_plain(rtu_pkg::ACT_EXPIRE, p);
          default:             send_read(p);
        endcase
      end else begin
        // abandon a frame part way through
        make_idle(p);
        send_frame(p, $urandom_range(6, 1), 1'b0, 1'b1);
        if ($urandom_range(1)) send_plain(rtu_pkg::ACT_START, p);
        for (i = 0; i < 3; i++) send_read(2'($urandom));
      end
    end
    wait_for_responses();
  endtask

  initial begin
    int p;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (p = 0; p < PORTS; p++) begin
      port_mode[p] = RX_INIT;
      port_count[p] = '0;
      port_crc[p] = rtu_pkg::CRC_INIT;
      store_fill[p] = 0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_startup();
    test_good_frame();
    test_short_frames();
    test_frame_limits();
    test_random(0, 0, 40);
    test_random(61, 0, 40);
    test_random(0, 61, 40);
    test_random(34, 34, 40);
    $display("tb_top: %0d events sent, %0d results checked", events_sent, responses_checked);
    $display("tb_top: %0d frames reported, %0d with a valid check, %0d mismatches",
             frames_reported, frames_good, error_count);
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

[rtu_frame_receiver.f]
+incdir+hw/rtl
hw/rtl/rtu_pkg.sv
hw/rtl/rtu_ram.sv
hw/rtl/rtu_front.sv
hw/rtl/rtu_queue.sv
hw/rtl/rtu_back.sv
hw/rtl/rtu_frame_receiver.sv
tb/tb_top.sv
